// ===== rtl/fir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types and constants of the streaming direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS);
  localparam int Y_W       = ACC_W - FRAC_BITS;

  localparam int TAP_CNT_W  = 7;
  localparam int COEFF_IDX_W = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = TAP_CNT_W'(48);

  localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT = '0;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEFF  = 1'b1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Y_W-1:0]   Y_MAX = Y_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_W-1:0]   Y_MIN = Y_W'(-(1 << (SAMPLE_BITS - 1)));

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEFF_IDX_W-1:0]        coeff_index;
    logic signed [SAMPLE_BITS-1:0] coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } fir_state_t;

endpackage

// ===== rtl/fir_filter_stream_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_stream_core
// Direct-form FIR filter: delay line and coefficients in two synchronous RAMs,
// one multiply-accumulate per tap per cycle, Q1.15 rounding and saturation.
// ----------------------------------------------------------------------------
// A coefficient-load transaction gives no result. A sample transaction sweeps
// the active taps one per cycle: each cycle reads one delay-line entry and one
// coefficient, writes the entry back one place lower and feeds the single 16x16
// multiplier. With tap_count clamped to 1..64 active taps, the products pass the
// product register into the accumulator; the rounded, saturated sum is registered
// and then loaded into the output register, after which the next transaction is
// taken. The input stalls for the whole sweep; a finished result may wait in the
// output register while the next transaction is taken. Both RAMs read as zero
// after reset through per-entry valid bits, so there is no clearing pass.
module fir_filter_stream_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fir_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fir_pkg::out_item_t                   out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fir_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [fir_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [fir_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);
  import fir_pkg::*;

  fir_state_t state_r, state_nxt;

  logic [TAP_CNT_W-1:0]          tap_count_r;
  logic [TAP_IDX_W-1:0]          last_r;
  logic [TAP_IDX_W-1:0]          rd_idx_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  // memories and their valid bits
  logic signed [SAMPLE_BITS-1:0] dl_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           dl_vld_r;
  logic [MAX_TAPS-1:0]           cf_vld_r;
  logic signed [SAMPLE_BITS-1:0] dl_rdata_r;
  logic signed [SAMPLE_BITS-1:0] cf_rdata_r;
  logic                          dl_rvld_r;
  logic                          cf_rvld_r;
  logic [TAP_IDX_W-1:0]          dl_raddr;

  // sweep pipeline
  logic                          s1_vld_r;
  logic                          s1_last_r;
  logic [TAP_IDX_W-1:0]          s1_idx_r;
  logic                          s2_vld_r;
  logic                          s2_last_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [SAMPLE_BITS-1:0] tap_data;
  logic signed [SAMPLE_BITS-1:0] tap_coeff;
  logic signed [ACC_W-1:0]       acc_r;
  logic                          acc_done_r;

  // rounding and result
  logic signed [ACC_W-1:0]       acc_rnd;
  logic signed [Y_W-1:0]         y_full;
  logic signed [SAMPLE_BITS-1:0] res_val_r;
  logic                          res_sat_r;
  logic                          out_valid_r;
  out_item_t                     out_data_r;

  logic accept;
  logic accept_sample;
  logic coeff_we;
  logic run_en;
  logic out_load;
  logic out_take;
  logic cfg_wr;
  logic [TAP_IDX_W-1:0] last_nxt;

  assign accept        = in_valid && !in_stall;
  assign accept_sample = accept && (in_data.func == FUNC_SAMPLE);
  assign coeff_we      = accept && (in_data.func == FUNC_COEFF)
                         && (int'(in_data.coeff_index) < MAX_TAPS);
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_take      = out_valid_r && !out_stall;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_TAP_COUNT) ? CFG_DATA_W'(tap_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_wr && cfg_paddr == REG_TAP_COUNT) begin
      tap_count_r <= cfg_pwdata[TAP_CNT_W-1:0];
    end
  end

  // clamp the tap count to 1 .. MAX_TAPS, kept as the last tap index
  always_comb begin
    if (tap_count_r == '0) begin
      last_nxt = '0;
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      last_nxt = TAP_IDX_W'(MAX_TAPS - 1);
    end else begin
      last_nxt = TAP_IDX_W'(tap_count_r - TAP_CNT_W'(1));
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    run_en    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept_sample) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        run_en = 1'b1;
        if (rd_idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept_sample) begin
      last_r   <= last_nxt;
      sample_r <= in_data.sample_in;
    end
    if (accept_sample) begin
      rd_idx_r <= '0;
    end else if (run_en) begin
      rd_idx_r <= rd_idx_r + TAP_IDX_W'(1);
    end
  end

  // read entry k+1 of the delay line, it moves down into entry k
  assign dl_raddr = rd_idx_r + TAP_IDX_W'(1);

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      dl_mem[s1_idx_r] <= tap_data;
    end
    dl_rdata_r <= dl_mem[dl_raddr];
    dl_rvld_r  <= dl_vld_r[dl_raddr];
  end

  always_ff @(posedge clk) begin
    if (coeff_we) begin
      cf_mem[TAP_IDX_W'(in_data.coeff_index)] <= in_data.coeff_value;
    end
    cf_rdata_r <= cf_mem[rd_idx_r];
    cf_rvld_r  <= cf_vld_r[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r <= '0;
      cf_vld_r <= '0;
    end else begin
      if (s1_vld_r) begin
        dl_vld_r[s1_idx_r] <= 1'b1;
      end
      if (coeff_we) begin
        cf_vld_r[TAP_IDX_W'(in_data.coeff_index)] <= 1'b1;
      end
    end
  end

  // the last active tap takes the new sample
  always_comb begin
    if (s1_last_r) begin
      tap_data = sample_r;
    end else if (dl_rvld_r) begin
      tap_data = dl_rdata_r;
    end else begin
      tap_data = '0;
    end
    tap_coeff = cf_rvld_r ? cf_rdata_r : '0;
    prod_nxt  = PROD_W'(tap_data) * PROD_W'(tap_coeff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_vld_r   <= 1'b0;
      s2_last_r  <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      s1_vld_r   <= run_en;
      s1_last_r  <= run_en && (rd_idx_r == last_r);
      s2_vld_r   <= s1_vld_r;
      s2_last_r  <= s1_vld_r && s1_last_r;
      acc_done_r <= s2_vld_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= rd_idx_r;
    prod_r   <= prod_nxt;
    if (accept_sample) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  assign acc_rnd = acc_r + ROUND_HALF;
  assign y_full  = acc_rnd[ACC_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN && acc_done_r) begin
      if (y_full > Y_MAX) begin
        res_val_r <= SAMPLE_BITS'(Y_MAX);
        res_sat_r <= 1'b1;
      end else if (y_full < Y_MIN) begin
        res_val_r <= SAMPLE_BITS'(Y_MIN);
        res_sat_r <= 1'b1;
      end else begin
        res_val_r <= SAMPLE_BITS'(y_full);
        res_sat_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.filtered  <= res_val_r;
      out_data_r.saturated <= res_sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !s1_vld_r && !s2_vld_r && !acc_done_r)
    else $error("sweep pipeline busy while idle");

  a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> s1_idx_r <= last_r)
    else $error("delay line write beyond active taps");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result loaded outside finish state");

  a_sample_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    accept_sample |=> state_r == ST_RUN && rd_idx_r == '0)
    else $error("sample transaction did not start a sweep");

  a_coeff_no_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == FUNC_COEFF |=> state_r == ST_IDLE)
    else $error("coefficient load left idle");
`endif

endmodule
